>>> hdl/cdd_pkg.sv
package cdd_pkg;

	localparam int YEAR_BITS = 14;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [4:0] LEN_SHORT = 5'd30;
	localparam logic [4:0] LEN_LONG  = 5'd31;
	localparam logic [4:0] LEN_FEB   = 5'd28;
	localparam logic [4:0] LEN_FEB_LEAP = 5'd29;

	localparam logic [1:0] ORDER_EQUAL   = 2'd0;
	localparam logic [1:0] ORDER_A_FIRST = 2'd1;
	localparam logic [1:0] ORDER_B_FIRST = 2'd2;

	typedef struct packed {
		logic [YEAR_BITS-1:0] year_a;
		logic [3:0]           month_a;
		logic [4:0]           day_a;
		logic [YEAR_BITS-1:0] year_b;
		logic [3:0]           month_b;
		logic [4:0]           day_b;
	} dates_t;

	typedef struct packed {
		logic [YEAR_BITS-1:0] diff_years;
		logic [3:0]           diff_months;
		logic [4:0]           diff_days;
		logic [1:0]           order;
		logic                 invalid;
	} diff_t;

	// Length of a month; codes outside 1..12 read as a long month.
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month) inside
			MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage

>>> hdl/cdd_leap.sv
// Gregorian leap test. Divisibility by 25 uses the modular inverse of 25:
// y is a multiple of 25 exactly when y * inv(25) mod 2^N <= (2^N - 1) / 25.
module cdd_leap (
	input  logic [cdd_pkg::YEAR_BITS-1:0] year,
	output logic                          leap
);

	localparam int N = cdd_pkg::YEAR_BITS;
	localparam logic [N-1:0] INV25 = N'(32'hC28F5C29);
	localparam logic [N-1:0] LIM25 = N'(((64'd1 << N) - 64'd1) / 64'd25);

	logic [N-1:0] prod;
	logic         div25;
	logic         div4;
	logic         div16;

	assign prod  = year * INV25;
	assign div25 = (prod <= LIM25);
	assign div4  = (year[1:0] == 2'b00);
	assign div16 = (year[3:0] == 4'b0000);

	// by 4 and not by 100, or by 400 (= by 16 and by 25)
	assign leap = (div4 && !div25) || (div16 && div25);

endmodule

>>> hdl/calendar_date_difference.sv
// Gregorian date difference. One transaction per clock: start is taken whenever
// it is high, busy always reads low. The dates go into an input register and the
// whole check, ordering and borrow settle combinationally into the result register
// behind it, so done is high once that register has loaded, for exactly one
// cycle; the receiver cannot stall and must capture diff on that cycle. A bad
// month or day in either date gives invalid = 1 and zeros.
module calendar_date_difference (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  cdd_pkg::dates_t dates,
	output logic            done,
	output cdd_pkg::diff_t  diff
);

	localparam int YB = cdd_pkg::YEAR_BITS;

	function automatic logic [3:0] prev_month(input logic [3:0] month);
		logic [3:0] pm;
		pm = (month == cdd_pkg::MONTH_JAN) ? cdd_pkg::MONTH_DEC : month - 4'd1;
		return pm;
	endfunction

	function automatic logic date_ok(input logic [3:0] month, input logic [4:0] day,
			input logic leap);
		logic ok;
		ok = (month >= cdd_pkg::MONTH_JAN) && (month <= cdd_pkg::MONTH_DEC) &&
			(day != 5'd0) && (day <= cdd_pkg::month_len(month, leap));
		return ok;
	endfunction

	// input register
	logic            vld_s1;
	cdd_pkg::dates_t dates_s1;

	logic            leap_a;
	logic            leap_b;

	logic            done_q;
	cdd_pkg::diff_t  diff_q;

	assign busy = 1'b0;

	cdd_leap u_leap_a (.year(dates_s1.year_a), .leap(leap_a));
	cdd_leap u_leap_b (.year(dates_s1.year_b), .leap(leap_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			dates_s1 <= dates;
		end
	end

	// validate, order, subtract and borrow
	logic                   ok;
	logic [YB+8:0]          key_a;
	logic [YB+8:0]          key_b;
	logic                   a_first;
	logic                   same;
	logic [YB-1:0]          y1;
	logic [YB-1:0]          y2;
	logic [3:0]             m1;
	logic [3:0]             m2;
	logic [4:0]             d1;
	logic [4:0]             d2;
	logic                   leap2;
	logic [3:0]             bm1;
	logic [3:0]             bm2;
	logic signed [6:0]      days0;
	logic signed [6:0]      days1;
	logic signed [6:0]      days2;
	logic signed [5:0]      mon0;
	logic signed [5:0]      mon1;
	logic signed [5:0]      mon2;
	logic signed [5:0]      mon3;
	logic [YB-1:0]          yrs0;
	logic [YB-1:0]          yrs1;
	logic                   yrs_under;
	cdd_pkg::diff_t         diff_d;

	always_comb begin
		ok = date_ok(dates_s1.month_a, dates_s1.day_a, leap_a) &&
			date_ok(dates_s1.month_b, dates_s1.day_b, leap_b);

		key_a   = {dates_s1.year_a, dates_s1.month_a, dates_s1.day_a};
		key_b   = {dates_s1.year_b, dates_s1.month_b, dates_s1.day_b};
		a_first = key_a < key_b;
		same    = key_a == key_b;

		if (a_first) begin
			y1 = dates_s1.year_a;  m1 = dates_s1.month_a; d1 = dates_s1.day_a;
			y2 = dates_s1.year_b;  m2 = dates_s1.month_b; d2 = dates_s1.day_b;
			leap2 = leap_b;
		end else begin
			y1 = dates_s1.year_b;  m1 = dates_s1.month_b; d1 = dates_s1.day_b;
			y2 = dates_s1.year_a;  m2 = dates_s1.month_a; d2 = dates_s1.day_a;
			leap2 = leap_a;
		end

		yrs0  = y2 - y1;
		mon0  = $signed({2'b00, m2}) - $signed({2'b00, m1});
		days0 = $signed({2'b00, d2}) - $signed({2'b00, d1});

		// February can only be reached in the later date's own year, so its
		// leap flag covers both borrows; a wrap lands in December or November.
		bm1 = prev_month(m2);
		bm2 = prev_month(bm1);

		if (days0 < 0) begin
			days1 = days0 + $signed({2'b00, cdd_pkg::month_len(bm1, leap2)});
			mon1  = mon0 - 6'sd1;
		end else begin
			days1 = days0;
			mon1  = mon0;
		end

		if (days1 < 0) begin
			days2 = days1 + $signed({2'b00, cdd_pkg::month_len(bm2, leap2)});
			mon2  = mon1 - 6'sd1;
		end else begin
			days2 = days1;
			mon2  = mon1;
		end

		if (mon2 < 0) begin
			mon3      = mon2 + 6'sd12;
			yrs1      = yrs0 - YB'(1);
			yrs_under = (yrs0 == '0);
		end else begin
			mon3      = mon2;
			yrs1      = yrs0;
			yrs_under = 1'b0;
		end

		diff_d             = '0;
		diff_d.invalid     = !ok;
		if (ok && !same) begin
			diff_d.diff_years  = yrs_under ? '0 : yrs1;
			diff_d.diff_months = (mon3 < 0) ? 4'd0 : mon3[3:0];
			diff_d.diff_days   = (days2 < 0) ? 5'd0 : days2[4:0];
			diff_d.order       = a_first ? cdd_pkg::ORDER_A_FIRST : cdd_pkg::ORDER_B_FIRST;
		end else if (ok) begin
			diff_d.order = cdd_pkg::ORDER_EQUAL;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			diff_q <= diff_d;
		end
	end

	assign done = done_q;
	assign diff = diff_q;

endmodule

>>> tb/sv/calendar_date_difference_tb.sv
module calendar_date_difference_tb;

	localparam int LATENCY   = 2;
	localparam int LIMIT     = 200000;
	localparam int YEAR_MAX  = (1 << cdd_pkg::YEAR_BITS) - 1;
	localparam logic [cdd_pkg::YEAR_BITS-1:0] YEAR_TOP = '1;
	localparam int PHASE_LEN = 160;
	localparam int N_ROWS    = 22;
	localparam int MAX_PRINT = 60;
	// Third phase is the receiver-stall slot: done cannot be held off, so the sender runs flat out.
	localparam int IDLE_PCT [4] = '{0, 52, 0, 10};

	localparam cdd_pkg::diff_t NO_SPAN    = '0;
	localparam cdd_pkg::diff_t BAD_SPAN   = '{diff_years: '0, diff_months: '0, diff_days: '0,
		order: cdd_pkg::ORDER_EQUAL, invalid: 1'b1};
	localparam cdd_pkg::diff_t EQUAL_SPAN = '{diff_years: '0, diff_months: '0, diff_days: '0,
		order: cdd_pkg::ORDER_EQUAL, invalid: 1'b0};

	typedef struct {
		cdd_pkg::dates_t pair;
		bit              fixed;
		cdd_pkg::diff_t  span;
	} date_row_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            start;
	logic            busy;
	cdd_pkg::dates_t dates;
	logic            done;
	cdd_pkg::diff_t  diff;

	cdd_pkg::diff_t span_q[$];
	cdd_pkg::diff_t want_span;
	date_row_t dir_rows [N_ROWS];
	int        cycles = 0;
	int        errors = 0;
	int        sent = 0;
	int        checked = 0;
	int        n_invalid = 0;
	int        n_equal = 0;
	int        n_forward = 0;
	int        n_backward = 0;

	calendar_date_difference DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dates  (dates),
		.done   (done),
		.diff   (diff)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit leap_of(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_days(input int y, input int m);
		int len;
		if (m == int'(cdd_pkg::MONTH_FEB))
			len = leap_of(y) ? 29 : 28;
		else if (m == int'(cdd_pkg::MONTH_APR) || m == int'(cdd_pkg::MONTH_JUN) ||
				m == int'(cdd_pkg::MONTH_SEP) || m == int'(cdd_pkg::MONTH_NOV))
			len = 30;
		else
			len = 31;
		return len;
	endfunction

	function automatic bit date_valid(input int y, input int m, input int d);
		return (m >= int'(cdd_pkg::MONTH_JAN)) && (m <= int'(cdd_pkg::MONTH_DEC)) &&
			(d >= 1) && (d <= month_days(y, m));
	endfunction

	// Expected distance between the two dates of one transaction.
	function automatic cdd_pkg::diff_t date_span(input cdd_pkg::dates_t p);
		cdd_pkg::diff_t r;
		int ya, ma, da, yb, mb, db;
		int y1, m1, d1, y2, m2, d2;
		int yrs, mons, dys, by, bm, cmp, k;
		logic [1:0] ord;
		r = EQUAL_SPAN;
		ya = int'(p.year_a);
		ma = int'(p.month_a);
		da = int'(p.day_a);
		yb = int'(p.year_b);
		mb = int'(p.month_b);
		db = int'(p.day_b);
		if (!date_valid(ya, ma, da) || !date_valid(yb, mb, db))
			return BAD_SPAN;
		cmp = ya - yb;
		if (cmp == 0)
			cmp = ma - mb;
		if (cmp == 0)
			cmp = da - db;
		if (cmp == 0)
			return r;
		if (cmp < 0) begin
			ord = cdd_pkg::ORDER_A_FIRST;
			y1 = ya; m1 = ma; d1 = da; y2 = yb; m2 = mb; d2 = db;
		end else begin
			ord = cdd_pkg::ORDER_B_FIRST;
			y1 = yb; m1 = mb; d1 = db; y2 = ya; m2 = ma; d2 = da;
		end
		yrs = y2 - y1;
		mons = m2 - m1;
		dys = d2 - d1;
		// borrow the months just before the later date, wrapping into last December
		by = y2;
		bm = m2;
		for (k = 0; k < 2 && dys < 0; k++) begin
			if (bm == int'(cdd_pkg::MONTH_JAN)) begin
				bm = int'(cdd_pkg::MONTH_DEC);
				by = by - 1;
			end else begin
				bm = bm - 1;
			end
			dys += month_days(by, bm);
			mons -= 1;
		end
		if (mons < 0) begin
			mons += 12;
			yrs -= 1;
		end
		if (yrs < 0) yrs = 0;
		if (mons < 0) mons = 0;
		if (dys < 0) dys = 0;
		r.diff_years = yrs[cdd_pkg::YEAR_BITS-1:0];
		r.diff_months = mons[3:0];
		r.diff_days = dys[4:0];
		r.order = ord;
		r.invalid = 1'b0;
		return r;
	endfunction

	function automatic cdd_pkg::dates_t pack_dates(input int ya, input int ma, input int da,
			input int yb, input int mb, input int db);
		cdd_pkg::dates_t p;
		p.year_a = ya[cdd_pkg::YEAR_BITS-1:0];
		p.month_a = ma[3:0];
		p.day_a = da[4:0];
		p.year_b = yb[cdd_pkg::YEAR_BITS-1:0];
		p.month_b = mb[3:0];
		p.day_b = db[4:0];
		return p;
	endfunction

	// Day in a month, leaning on the first and last days where borrows happen.
	function automatic int pick_day(input int y, input int m);
		int len;
		len = month_days(y, m);
		case ($urandom_range(9))
			0: return 1;
			1: return len;
			2: return len - 1;
			default: return $urandom_range(len, 1);
		endcase
	endfunction

	function automatic int pick_year();
		return ($urandom_range(7) == 0) ? $urandom_range(YEAR_MAX) : $urandom_range(9999);
	endfunction

	function automatic cdd_pkg::dates_t random_dates();
		int kind, ya, ma, da, yb, mb, db;
		kind = $urandom_range(99);
		ya = pick_year();
		ma = $urandom_range(12, 1);
		da = pick_day(ya, ma);
		if (kind < 15) begin
			yb = pick_year();
			mb = $urandom_range(12, 1);
			db = pick_day(yb, mb);
		end else if (kind < 60) begin
			// nearby dates: within a year or so, which exercises the borrows
			yb = ya + $urandom_range(2) - 1;
			if (yb < 0) yb = 0;
			if (yb > YEAR_MAX) yb = YEAR_MAX;
			mb = (kind < 35) ? ma : $urandom_range(12, 1);
			db = pick_day(yb, mb);
		end else if (kind < 70) begin
			yb = ya;
			mb = ma;
			db = (kind < 65) ? da : pick_day(yb, mb);
		end else if (kind < 82) begin
			// month-end against month-start in the following month
			yb = (ma == int'(cdd_pkg::MONTH_DEC)) ? ya + 1 : ya;
			if (yb > YEAR_MAX) yb = YEAR_MAX;
			mb = (ma == int'(cdd_pkg::MONTH_DEC)) ? int'(cdd_pkg::MONTH_JAN) : ma + 1;
			da = month_days(ya, ma);
			db = $urandom_range(2, 1);
		end else begin
			ma = $urandom_range(15);
			da = $urandom_range(31);
			yb = $urandom_range(YEAR_MAX);
			mb = $urandom_range(15);
			db = $urandom_range(31);
		end
		if ($urandom_range(1))
			return pack_dates(ya, ma, da, yb, mb, db);
		return pack_dates(yb, mb, db, ya, ma, da);
	endfunction

	task automatic flag_mismatch(input string msg);
		if (errors < MAX_PRINT)
			$display("ERROR cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic send_dates(input cdd_pkg::dates_t p, input bit fixed,
			input cdd_pkg::diff_t span, input int idle_pct);
		cdd_pkg::diff_t want;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		dates <= p;
		do @(posedge clk); while (busy);
		want = fixed ? span : date_span(p);
		span_q.push_back(want);
		sent++;
		if (want.invalid)
			n_invalid++;
		else if (want.order == cdd_pkg::ORDER_EQUAL)
			n_equal++;
		else if (want.order == cdd_pkg::ORDER_A_FIRST)
			n_forward++;
		else
			n_backward++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("calendar_date_difference: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done) begin
			if (span_q.size() == 0) begin
				flag_mismatch("result with no transaction outstanding");
			end else begin
				want_span = span_q.pop_front();
				checked++;
				if (diff.diff_years !== want_span.diff_years)
					flag_mismatch($sformatf("diff_years got %0d want %0d",
						diff.diff_years, want_span.diff_years));
				if (diff.diff_months !== want_span.diff_months)
					flag_mismatch($sformatf("diff_months got %0d want %0d",
						diff.diff_months, want_span.diff_months));
				if (diff.diff_days !== want_span.diff_days)
					flag_mismatch($sformatf("diff_days got %0d want %0d",
						diff.diff_days, want_span.diff_days));
				if (diff.order !== want_span.order)
					flag_mismatch($sformatf("order got %0d want %0d",
						diff.order, want_span.order));
				if (diff.invalid !== want_span.invalid)
					flag_mismatch($sformatf("invalid got %0b want %0b",
						diff.invalid, want_span.invalid));
			end
		end
	end

	initial begin
		int ph;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		dates = '0;
		dir_rows = '{
			'{pack_dates(2024, 2, 29, 2024, 2, 29), 1'b1, EQUAL_SPAN},
			'{pack_dates(2023, 0, 15, 2023, 5, 15), 1'b1, BAD_SPAN},
			'{pack_dates(2023, 5, 15, 2023, 13, 1), 1'b1, BAD_SPAN},
			'{pack_dates(2023, 15, 31, 2023, 1, 1), 1'b1, BAD_SPAN},
			'{pack_dates(2023, 3, 0, 2023, 3, 1), 1'b1, BAD_SPAN},
			'{pack_dates(2023, 4, 31, 2023, 5, 1), 1'b1, BAD_SPAN},
			'{pack_dates(1900, 2, 29, 1901, 1, 1), 1'b1, BAD_SPAN},
			'{pack_dates(2023, 1, 1, 2023, 2, 29), 1'b1, BAD_SPAN},
			'{pack_dates(0, 2, 29, 0, 3, 1), 1'b0, NO_SPAN},
			'{pack_dates(2000, 2, 29, 2100, 2, 28), 1'b0, NO_SPAN},
			'{pack_dates(0, 1, 1, YEAR_MAX, 12, 31), 1'b1,
				'{YEAR_TOP, 4'd11, 5'd30, cdd_pkg::ORDER_A_FIRST, 1'b0}},
			'{pack_dates(YEAR_MAX, 12, 31, 0, 1, 1), 1'b1,
				'{YEAR_TOP, 4'd11, 5'd30, cdd_pkg::ORDER_B_FIRST, 1'b0}},
			'{pack_dates(2023, 1, 31, 2023, 3, 1), 1'b0, NO_SPAN},
			'{pack_dates(2022, 12, 31, 2023, 1, 1), 1'b0, NO_SPAN},
			'{pack_dates(2024, 1, 31, 2024, 3, 1), 1'b0, NO_SPAN},
			'{pack_dates(2024, 5, 1, 2024, 5, 31), 1'b0, NO_SPAN},
			'{pack_dates(9999, 12, 31, 9999, 12, 30), 1'b0, NO_SPAN},
			'{pack_dates(YEAR_MAX, 15, 31, YEAR_MAX, 15, 31), 1'b1, BAD_SPAN},
			'{pack_dates(0, 0, 0, 0, 0, 0), 1'b1, BAD_SPAN},
			'{pack_dates(1999, 12, 31, 2000, 1, 1), 1'b0, NO_SPAN},
			'{pack_dates(2023, 3, 31, 2023, 3, 31), 1'b1, EQUAL_SPAN},
			'{pack_dates(2020, 3, 30, 2021, 3, 1), 1'b0, NO_SPAN}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_dates(dir_rows[i].pair, dir_rows[i].fixed, dir_rows[i].span, 0);

		for (ph = 0; ph < 4; ph++) begin
			if (ph > 0) begin
				// hold off until the pipeline is empty
				start <= 1'b0;
				@(posedge clk);
				while (span_q.size() != 0)
					@(posedge clk);
			end
			repeat (PHASE_LEN)
				send_dates(random_dates(), 1'b0, NO_SPAN, IDLE_PCT[ph]);
		end
		start <= 1'b0;

		for (n = 0; n < 1000 && span_q.size() != 0; n++)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		if (span_q.size() != 0)
			flag_mismatch($sformatf("%0d transactions never produced a result",
				span_q.size()));

		$display("Sent %0d date pairs, checked %0d results: %0d invalid, %0d equal,",
			sent, checked, n_invalid, n_equal);
		$display("  %0d with A earlier, %0d with B earlier, over four idle phases",
			n_forward, n_backward);
		if (errors == 0)
			$display("calendar_date_difference: match");
		else
			$display("calendar_date_difference: mismatch");
		$finish;
	end

endmodule

>>> sim.f
hdl/cdd_pkg.sv
hdl/cdd_leap.sv
hdl/calendar_date_difference.sv
tb/sv/calendar_date_difference_tb.sv
